/* rtl/rbn_pkg.sv */
// Shared constants and types for the receive bitmap NACK scanner.
package rbn_pkg;

  // Fixed field widths.
  localparam int IDX_W = 10;
  localparam int SEQ_W = 32;
  localparam int CNT_W = 11;

  // Arrival counter saturates here.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Default bitmap depth.
  localparam int DEF_MAX_PACKETS = 1024;

  // Command codes.
  localparam logic CMD_MARK = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  // Configuration port geometry and register map.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_LAST_SEQ = 1'b0;

  // Control strobes from the sequencer to the bitmap memory.
  typedef struct packed {
    logic we;
    logic wdata;
    logic re;
  } rbn_mem_ctl_t;

endpackage

/* rtl/rbn_bitmap_mem.sv */
// One-bit-wide bitmap memory with one write port and one registered read port.
module rbn_bitmap_mem #(
  parameter int MAX_PACKETS = rbn_pkg::DEF_MAX_PACKETS
) (
  input  logic                           clk,
  input  rbn_pkg::rbn_mem_ctl_t          mem_ctl,
  input  logic [$clog2(MAX_PACKETS)-1:0] waddr,
  input  logic [$clog2(MAX_PACKETS)-1:0] raddr,
  output logic                           rdata
);
  import rbn_pkg::*;

  logic mem [MAX_PACKETS];

  // Write port.
  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[waddr] <= mem_ctl.wdata;
    end
  end

  // Registered read port, updated only when re is high.
  always_ff @(posedge clk) begin
    if (mem_ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rbn_apb_regs.sv */
// APB configuration register holding the last sequence number.
module rbn_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbn_pkg::PADDR_W-1:0] paddr,
  input  logic [rbn_pkg::PDATA_W-1:0] pwdata,
  output logic [rbn_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [rbn_pkg::IDX_W-1:0]   last_sequence
);
  import rbn_pkg::*;

  logic wr_en;
  logic reg_sel;

  // The word index is the address bit above the byte offset.
  assign reg_sel = (paddr[PADDR_W-1] == REG_LAST_SEQ);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Register write; writes to unmapped words are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sequence <= '0;
    end else if (wr_en && reg_sel) begin
      last_sequence <= pwdata[IDX_W-1:0];
    end
  end

  // Read data mux.
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = PDATA_W'(last_sequence);
    end
  end

endmodule

/* rtl/rbn_ctrl.sv */
// Sequencer for the bitmap: clearing sweep, mark read-modify-write and scan walk.
module rbn_ctrl #(
  parameter int MAX_PACKETS = rbn_pkg::DEF_MAX_PACKETS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [rbn_pkg::SEQ_W-1:0]      sequence_number,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           newly_received,
  output logic                           missing_found,
  output logic [rbn_pkg::IDX_W-1:0]      missing_index,
  output logic                           all_received,
  input  logic [rbn_pkg::IDX_W-1:0]      last_sequence,
  output rbn_pkg::rbn_mem_ctl_t          mem_ctl,
  output logic [$clog2(MAX_PACKETS)-1:0] mem_waddr,
  output logic [$clog2(MAX_PACKETS)-1:0] mem_raddr,
  input  logic                           mem_rdata
);
  import rbn_pkg::*;

  localparam int AW  = $clog2(MAX_PACKETS);
  localparam int LIM = (MAX_PACKETS - 1 < (1 << IDX_W) - 1) ?
                       MAX_PACKETS - 1 : (1 << IDX_W) - 1;
  localparam logic [IDX_W-1:0] LIM_IDX  = IDX_W'(LIM);
  localparam logic [AW-1:0]    CLR_LAST = AW'(MAX_PACKETS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MARK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Widen or narrow a sequence index to a memory address.
  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] i);
    logic [AW+IDX_W-1:0] w;
    w = {{AW{1'b0}}, i};
    return w[AW-1:0];
  endfunction

  logic [2:0]       state, state_next;
  logic [AW-1:0]    clr_addr, clr_addr_next;
  logic [AW-1:0]    seq_addr, seq_addr_next;
  logic [IDX_W-1:0] cur, cur_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             res_newly, res_newly_next;
  logic             res_found, res_found_next;
  logic [IDX_W-1:0] res_idx, res_idx_next;
  logic             out_valid_next;
  logic             newly_next, found_next, all_next;
  logic [IDX_W-1:0] index_next;
  logic [IDX_W-1:0] eff_last;
  logic             in_range;

  // Last sequence clipped to the bitmap depth.
  assign eff_last = (last_sequence < LIM_IDX) ? last_sequence : LIM_IDX;
  assign in_range = (sequence_number <= SEQ_W'(eff_last));
  assign in_ready = (state == S_IDLE);

  // Next-state and datapath logic.
  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    seq_addr_next  = seq_addr;
    cur_next       = cur;
    ptr_next       = ptr;
    count_next     = count;
    res_newly_next = res_newly;
    res_found_next = res_found;
    res_idx_next   = res_idx;
    out_valid_next = out_valid && !out_ready;
    newly_next     = newly_received;
    found_next     = missing_found;
    index_next     = missing_index;
    all_next       = all_received;
    mem_ctl        = '0;
    mem_waddr      = seq_addr;
    mem_raddr      = to_addr(ptr);

    case (state)
      S_CLEAR: begin
        // Sweep the bitmap to zero, one entry a cycle.
        mem_ctl.we    = 1'b1;
        mem_ctl.wdata = 1'b0;
        mem_waddr     = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_newly_next = 1'b0;
          res_found_next = 1'b0;
          res_idx_next   = '0;
          if (command == CMD_MARK) begin
            if (in_range) begin
              // Fetch the current bit for the read-modify-write.
              mem_raddr     = to_addr(sequence_number[IDX_W-1:0]);
              mem_ctl.re    = 1'b1;
              seq_addr_next = to_addr(sequence_number[IDX_W-1:0]);
              state_next    = S_MARK;
            end else begin
              state_next = S_DONE;
            end
          end else begin
            if (ptr > eff_last) begin
              ptr_next   = '0;
              state_next = S_DONE;
            end else begin
              mem_raddr  = to_addr(ptr);
              mem_ctl.re = 1'b1;
              cur_next   = ptr;
              state_next = S_SCAN;
            end
          end
        end
      end
      S_MARK: begin
        // Set a clear bit and count the new arrival.
        if (!mem_rdata) begin
          mem_ctl.we     = 1'b1;
          mem_ctl.wdata  = 1'b1;
          mem_waddr      = seq_addr;
          res_newly_next = 1'b1;
          if (count != CNT_MAX) begin
            count_next = count + CNT_W'(1);
          end
        end
        state_next = S_DONE;
      end
      S_SCAN: begin
        // Check one entry a cycle until a clear bit or the last entry.
        if (!mem_rdata) begin
          res_found_next = 1'b1;
          res_idx_next   = cur;
          ptr_next       = (cur == eff_last) ? '0 : cur + IDX_W'(1);
          state_next     = S_DONE;
        end else if (cur == eff_last) begin
          ptr_next   = '0;
          state_next = S_DONE;
        end else begin
          mem_raddr  = to_addr(cur + IDX_W'(1));
          mem_ctl.re = 1'b1;
          cur_next   = cur + IDX_W'(1);
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          newly_next     = res_newly;
          found_next     = res_found;
          index_next     = res_idx;
          all_next       = (count == CNT_W'(eff_last) + CNT_W'(1));
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      ptr       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      ptr       <= ptr_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    seq_addr       <= seq_addr_next;
    cur            <= cur_next;
    res_newly      <= res_newly_next;
    res_found      <= res_found_next;
    res_idx        <= res_idx_next;
    newly_received <= newly_next;
    missing_found  <= found_next;
    missing_index  <= index_next;
    all_received   <= all_next;
  end

endmodule

/* rtl/receive_bitmap_nack_scanner_top.sv */
// Receive bitmap NACK scanner: marks arrivals, scans for missing sequence numbers.
// An in-range mark reads its bit and sets it if clear before its result word is made;
// an out-of-range mark goes straight to its result; a scan reads one bitmap entry at a
// time, set by the one-bit read port, up to last_sequence. A held output word stalls it.
// One word is in work at a time; the next is taken once the result is registered.
// Reset is synchronous; afterwards a clearing pass over all MAX_PACKETS entries zeroes the
// bitmap, with in_ready low and configuration writes still taken.
module receive_bitmap_nack_scanner_top #(
  parameter int MAX_PACKETS = rbn_pkg::DEF_MAX_PACKETS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic [rbn_pkg::SEQ_W-1:0]   sequence_number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        newly_received,
  output logic                        missing_found,
  output logic [rbn_pkg::IDX_W-1:0]   missing_index,
  output logic                        all_received,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbn_pkg::PADDR_W-1:0] paddr,
  input  logic [rbn_pkg::PDATA_W-1:0] pwdata,
  output logic [rbn_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import rbn_pkg::*;

  localparam int AW = $clog2(MAX_PACKETS);

  logic [IDX_W-1:0] last_sequence;
  rbn_mem_ctl_t     mem_ctl;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  logic             mem_rdata;

  // Configuration register.
  rbn_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .last_sequence (last_sequence)
  );

  // Sequencer.
  rbn_ctrl #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .sequence_number (sequence_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .newly_received  (newly_received),
    .missing_found   (missing_found),
    .missing_index   (missing_index),
    .all_received    (all_received),
    .last_sequence   (last_sequence),
    .mem_ctl         (mem_ctl),
    .mem_waddr       (mem_waddr),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  // Received bitmap.
  rbn_bitmap_mem #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_mem (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (mem_waddr),
    .raddr   (mem_raddr),
    .rdata   (mem_rdata)
  );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the receive bitmap NACK scanner top level.
module testbench;
  import rbn_pkg::*;

  localparam int MAX_PACKETS = DEF_MAX_PACKETS;
  localparam int IDLE_MAX = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = MAX_PACKETS + 80;
  localparam int REG_UNUSED = 1;

  // One result word as the block reports it.
  typedef struct packed {
    logic            newly;
    logic            found;
    logic [IDX_W-1:0] index;
    logic            done;
  } nack_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               command = CMD_MARK;
  logic [SEQ_W-1:0]   sequence_number = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               newly_received;
  logic               missing_found;
  logic [IDX_W-1:0]   missing_index;
  logic               all_received;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Predicted state of the receiver.
  logic [MAX_PACKETS-1:0] arrived_map = '0;
  logic [IDX_W-1:0]       nack_ptr = '0;
  logic [CNT_W-1:0]       arrivals = '0;
  logic [IDX_W-1:0]       last_cfg = '0;

  nack_result_t expected_results[$];

  // Traffic shaping shared by the sender, the receiver and the tests.
  logic tx_idle = 1'b1;
  logic rx_idle = 1'b1;
  logic hold_request = 1'b0;

  int failures = 0;
  int words_sent = 0;
  int scans_sent = 0;
  int nacks_raised = 0;
  int new_arrivals = 0;
  int settings_used = 0;
  int holds_done = 0;

  receive_bitmap_nack_scanner_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .sequence_number (sequence_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .newly_received  (newly_received),
    .missing_found   (missing_found),
    .missing_index   (missing_index),
    .all_received    (all_received),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the result of one accepted word and advances the predicted state.
  function automatic nack_result_t predict_nack(input logic cmd,
                                                input logic [SEQ_W-1:0] seq);
    nack_result_t r;
    int i;
    r = '0;
    if (cmd == CMD_MARK) begin
      if (seq <= SEQ_W'(last_cfg) && !arrived_map[seq[IDX_W-1:0]]) begin
        arrived_map[seq[IDX_W-1:0]] = 1'b1;
        r.newly = 1'b1;
        if (arrivals != CNT_MAX) arrivals = arrivals + 1'b1;
      end
    end else begin
      // A pointer above the last number walks nothing and finds nothing.
      i = nack_ptr;
      while (!r.found && i <= last_cfg) begin
        if (!arrived_map[i]) begin
          r.found = 1'b1;
          r.index = IDX_W'(i);
        end
        i++;
      end
      if (r.found && r.index != last_cfg) nack_ptr = r.index + 1'b1;
      else nack_ptr = '0;
    end
    r.done = (arrivals == {1'b0, last_cfg} + 11'd1);
    return r;
  endfunction

  task automatic report_failure(input string what);
    failures++;
    if (failures <= 10) $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got)
      report_failure($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  // Offers one word, after a random gap when tx_idle is set, and records its expected result.
  task automatic send_word(input logic cmd, input logic [SEQ_W-1:0] seq,
                           output nack_result_t pred);
    int gap;
    logic took;
    gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    sequence_number <= seq;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    pred = predict_nack(cmd, seq);
    expected_results.push_back(pred);
    words_sent++;
    if (cmd == CMD_SCAN) scans_sent++;
    if (pred.found) nacks_raised++;
    if (pred.newly) new_arrivals++;
  endtask

  // Stops offering and waits until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write with setup and access cycles, only once the block is idle.
  task automatic write_register(input int index, input logic [PDATA_W-1:0] value);
    logic took;
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(index * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      took = pready;
      @(posedge clk);
    end while (!took);
    psel <= 1'b0;
    penable <= 1'b0;
    if (index == int'(REG_LAST_SEQ)) begin
      last_cfg = value[IDX_W-1:0];
      settings_used++;
    end
  endtask

  // Field extremes, duplicates, out-of-range marks and completion with the
  // last sequence at zero.
  task automatic test_boundaries();
    nack_result_t pred;
    send_word(CMD_SCAN, '0, pred);
    send_word(CMD_MARK, 32'd1, pred);
    send_word(CMD_MARK, 32'hFFFF_FFFF, pred);
    send_word(CMD_MARK, 32'd0, pred);
    send_word(CMD_MARK, 32'd0, pred);
    send_word(CMD_SCAN, 32'hFFFF_FFFF, pred);
    write_register(int'(REG_LAST_SEQ), 32'd1023);
    send_word(CMD_MARK, 32'd1023, pred);
    send_word(CMD_MARK, 32'd1024, pred);
    send_word(CMD_MARK, 32'h5555_5555, pred);
    send_word(CMD_MARK, 32'hAAAA_AAAA, pred);
  endtask

  // A write to an unmapped register must leave the last sequence alone.
  task automatic test_unused_register();
    nack_result_t pred;
    write_register(int'(REG_LAST_SEQ), 32'd0);
    write_register(REG_UNUSED, 32'd5);
    send_word(CMD_MARK, 32'd1, pred);
    write_register(int'(REG_LAST_SEQ), 32'd1023);
  endtask

  // Pointer advance, pointer left above a lowered last sequence, and wrap.
  task automatic test_pointer_rules();
    nack_result_t pred;
    send_word(CMD_SCAN, '0, pred);
    send_word(CMD_SCAN, '0, pred);
    write_register(int'(REG_LAST_SEQ), 32'd1);
    send_word(CMD_SCAN, '0, pred);
    send_word(CMD_SCAN, '0, pred);
    send_word(CMD_MARK, 32'd1, pred);
    send_word(CMD_MARK, 32'd2, pred);
    send_word(CMD_SCAN, '0, pred);
  endtask

  // Transfers of several lengths: arrivals, retransmit requests answered by
  // the matching mark, bare scans and stray numbers.
  task automatic test_random_transfers();
    int phase_last[6] = '{15, 7, 63, 200, 1023, 31};
    int phase_words[6] = '{75, 35, 175, 165, 65, 55};
    int sent;
    int pick;
    logic [SEQ_W-1:0] seq;
    nack_result_t pred;
    for (int p = 0; p < 6; p++) begin
      write_register(int'(REG_LAST_SEQ), phase_last[p]);
      tx_idle = (p % 3) != 1;
      rx_idle = (p % 3) != 2;
      sent = 0;
      while (sent < phase_words[p]) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          send_word(CMD_MARK, $urandom_range(0, phase_last[p]), pred);
          sent++;
        end else if (pick < 75) begin
          send_word(CMD_SCAN, $urandom, pred);
          sent++;
          if (pred.found) begin
            send_word(CMD_MARK, SEQ_W'(pred.index), pred);
            sent++;
          end
        end else if (pick < 85) begin
          send_word(CMD_SCAN, $urandom, pred);
          sent++;
        end else begin
          if (pick < 95) begin
            seq = $urandom;
            if (seq <= phase_last[p]) seq = phase_last[p] + 1;
          end else begin
            seq = phase_last[p] + $urandom_range(0, 1);
          end
          send_word(CMD_MARK, seq, pred);
          sent++;
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // The receiver stops for a long stretch while words keep coming.
  task automatic test_backpressure();
    nack_result_t pred;
    write_register(int'(REG_LAST_SEQ), 32'd1023);
    tx_idle = 1'b0;
    hold_request = 1'b1;
    repeat (24) send_word(CMD_MARK, $urandom_range(0, MAX_PACKETS - 1), pred);
    send_word(CMD_SCAN, '0, pred);
    tx_idle = 1'b1;
    drain_results();
  endtask

  // Takes each result word, after a random stall when rx_idle is set, and checks it.
  initial begin : result_checker
    int stall;
    logic took;
    nack_result_t got;
    nack_result_t want;
    wait (!rst);
    forever begin
      stall = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
        holds_done++;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        got = {newly_received, missing_found, missing_index, all_received};
        @(posedge clk);
      end while (!took);
      if (expected_results.size() == 0) begin
        report_failure("result word with no word outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("newly_received", want.newly, got.newly);
        check_field("missing_found", want.found, got.found);
        check_field("missing_index", want.index, got.index);
        check_field("all_received", want.done, got.done);
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Reset, the tests in turn, then the final verdict.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_boundaries();
    test_unused_register();
    test_pointer_rules();
    test_random_transfers();
    test_backpressure();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", expected_results.size()));
    $display("Sent %0d words (%0d scans, %0d NACKs, %0d new arrivals) over %0d settings.",
             words_sent, scans_sent, nacks_raised, new_arrivals, settings_used);
    $display("Receiver held off %0d time(s) for %0d cycles; %0d failure(s) seen.",
             holds_done, HOLD_CYCLES, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
